### hw/rtl/dtrh_pkg.sv
// Shared constants and types for the dual-text rolling hash match unit.
package dtrh_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BYTE_W = 8;
  localparam int HASH_W = 16;
  localparam int TOTAL_W = 16;
  localparam int PROD_W = BYTE_W + HASH_W;

  localparam logic [HASH_W-1:0] MODULUS_RESET = 16'd101;

  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [2*BYTE_W-1:0] pair_t;

endpackage

### hw/rtl/dtrh_req_if.sv
// Input channel: pattern bytes and text byte pairs.
interface dtrh_req_if;
  logic valid;
  logic ready;
  logic func;
  logic first;
  dtrh_pkg::byte_t byte_a;
  dtrh_pkg::byte_t byte_b;

  modport source (output valid, func, first, byte_a, byte_b, input ready);
  modport sink (input valid, func, first, byte_a, byte_b, output ready);
endinterface

### hw/rtl/dtrh_rsp_if.sv
// Output channel: per-window match flag and running match total.
interface dtrh_rsp_if;
  logic valid;
  logic ready;
  logic window_match;
  dtrh_pkg::total_t match_total;

  modport source (output valid, window_match, match_total, input ready);
  modport sink (input valid, window_match, match_total, output ready);
endinterface

### hw/rtl/dual_text_rolling_hash_match_unit.sv
// Top level of the dual-text rolling hash match unit.
// Text pair: ops LM to NB (none for an empty pattern), then the result is registered in ST_DONE;
// a result still held at the output holds the next one back and stalls the input.
// Pattern byte: hash step (first byte) or hash and power steps, none once full; no result.
// One modulo reducer folds 8 dividend bits per cycle, fed by one multiplier; window bytes in a RAM.
// Reset (rst, synchronous): modulus 101, pattern empty, hashes and count cleared; no clearing pass.
module dual_text_rolling_hash_match_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [15:0]              cfg_wr_data,
  dtrh_req_if.sink                 req,
  dtrh_rsp_if.source               rsp
);

  localparam int LEN_W = dtrh_pkg::LEN_W;
  localparam int ADDR_W = dtrh_pkg::ADDR_W;
  localparam int HASH_W = dtrh_pkg::HASH_W;
  localparam int BYTE_W = dtrh_pkg::BYTE_W;
  localparam int PROD_W = dtrh_pkg::PROD_W;
  localparam int COUNT_WIDTH = dtrh_pkg::COUNT_WIDTH;
  localparam int TOTAL_W = dtrh_pkg::TOTAL_W;
  localparam int MAX_PATTERN = dtrh_pkg::MAX_PATTERN;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_RED   = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [3:0] OP_PH = 4'd0;
  localparam logic [3:0] OP_LP = 4'd1;
  localparam logic [3:0] OP_LM = 4'd2;
  localparam logic [3:0] OP_PM = 4'd3;
  localparam logic [3:0] OP_DA = 4'd4;
  localparam logic [3:0] OP_HA = 4'd5;
  localparam logic [3:0] OP_NA = 4'd6;
  localparam logic [3:0] OP_DB = 4'd7;
  localparam logic [3:0] OP_HB = 4'd8;
  localparam logic [3:0] OP_NB = 4'd9;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  dtrh_pkg::hash_t hash_modulus;
  dtrh_pkg::hash_t m_eff;
  dtrh_pkg::hash_t ph;
  dtrh_pkg::hash_t lp;
  dtrh_pkg::hash_t lm;
  dtrh_pkg::hash_t pm;
  dtrh_pkg::hash_t ha;
  dtrh_pkg::hash_t hb;
  dtrh_pkg::hash_t term;
  dtrh_pkg::hash_t red_r;
  dtrh_pkg::hash_t load_init;
  dtrh_pkg::hash_t sub_v;
  logic [PROD_W-1:0] red_x;
  logic [PROD_W-1:0] load_x;
  logic [PROD_W-1:0] prod;
  logic [1:0] red_cnt;
  logic [1:0] load_cnt;
  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] plen_eff;
  logic [LEN_W-1:0] seen;
  logic [LEN_W-1:0] seen_next;
  logic [LEN_W-1:0] wpos_inc;
  logic [ADDR_W-1:0] wpos;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  dtrh_pkg::byte_t a_reg;
  dtrh_pkg::byte_t b_reg;
  dtrh_pkg::byte_t old_byte;
  dtrh_pkg::pair_t mem [MAX_PATTERN];
  dtrh_pkg::pair_t rd_pair;
  logic full;
  logic hit;
  logic hit_next;
  logic [2:0] state;
  logic [3:0] op;
  logic accept;
  logic mem_we;
  logic out_valid;
  logic out_match;
  dtrh_pkg::total_t out_total;

  function automatic dtrh_pkg::hash_t red8(dtrh_pkg::hash_t r, dtrh_pkg::byte_t bits,
                                           dtrh_pkg::hash_t m);
    logic [HASH_W:0] t;
    dtrh_pkg::hash_t acc;
    acc = r;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      acc = t[HASH_W-1:0];
    end
    return acc;
  endfunction

  function automatic dtrh_pkg::total_t total_of(logic [COUNT_WIDTH-1:0] c);
    if (COUNT_WIDTH > TOTAL_W && c > COUNT_WIDTH'(TOTAL_MAX)) begin
      return TOTAL_MAX;
    end
    return TOTAL_W'(c);
  endfunction

  assign m_eff = (hash_modulus == '0) ? HASH_W'(1) : hash_modulus;
  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.window_match = out_match;
  assign rsp.match_total = out_total;

  assign plen_eff = req.first ? '0 : plen;
  assign old_byte = !full ? '0 : (op == OP_DA) ? rd_pair[2*BYTE_W-1:BYTE_W]
                                               : rd_pair[BYTE_W-1:0];
  assign prod = PROD_W'(old_byte) * PROD_W'(lm);
  assign sub_v = (red_r >= term) ? red_r - term
               : HASH_W'({1'b0, red_r} + {1'b0, m_eff} - {1'b0, term});
  assign seen_next = full ? seen : seen + LEN_W'(1);
  assign wpos_inc = LEN_W'(wpos) + LEN_W'(1);
  assign hit_next = (seen_next >= plen) && (ha == pm) && (red_r == pm);
  assign count_next = (hit_next && !(&count)) ? count + COUNT_WIDTH'(1) : count;
  assign mem_we = (state == ST_APPLY) && (op == OP_NB);

  always_comb begin
    load_init = '0;
    load_x = '0;
    load_cnt = 2'd2;
    unique case (op) inside
      OP_PH: begin
        load_x = {ph, a_reg};
        load_cnt = 2'd3;
      end
      OP_LP: begin
        load_x = {lp, {BYTE_W{1'b0}}};
        load_cnt = 2'd3;
      end
      OP_LM: load_x = {lp, {BYTE_W{1'b0}}};
      OP_PM: load_x = {ph, {BYTE_W{1'b0}}};
      OP_DA, OP_DB: begin
        load_x = prod;
        load_cnt = 2'd3;
      end
      OP_HA: load_x = {ha, {BYTE_W{1'b0}}};
      OP_HB: load_x = {hb, {BYTE_W{1'b0}}};
      OP_NA: begin
        load_init = term;
        load_x = {a_reg, {HASH_W{1'b0}}};
        load_cnt = 2'd1;
      end
      OP_NB: begin
        load_init = term;
        load_x = {b_reg, {HASH_W{1'b0}}};
        load_cnt = 2'd1;
      end
      default: load_x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= dtrh_pkg::MODULUS_RESET;
    end else if (cfg_wr_en) begin
      hash_modulus <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.func == dtrh_pkg::FUNC_TEXT) begin
      rd_pair <= mem[wpos];
    end
    if (mem_we) begin
      mem[wpos] <= {a_reg, b_reg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_PH;
      ph <= '0;
      lp <= HASH_W'(1);
      plen <= '0;
      ha <= '0;
      hb <= '0;
      seen <= '0;
      wpos <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            a_reg <= req.byte_a;
            b_reg <= req.byte_b;
            if (req.func == dtrh_pkg::FUNC_PATTERN) begin
              if (req.first) begin
                ph <= '0;
                lp <= HASH_W'(1);
                plen <= '0;
                count <= '0;
              end
              ha <= '0;
              hb <= '0;
              seen <= '0;
              wpos <= '0;
              if (plen_eff < LEN_W'(MAX_PATTERN)) begin
                op <= OP_PH;
                state <= ST_LOAD;
              end
            end else begin
              full <= (seen >= plen);
              if (plen == '0) begin
                hit <= 1'b0;
                state <= ST_DONE;
              end else begin
                op <= OP_LM;
                state <= ST_LOAD;
              end
            end
          end
        end
        ST_LOAD: begin
          red_r <= load_init;
          red_x <= load_x;
          red_cnt <= load_cnt;
          state <= ST_RED;
        end
        ST_RED: begin
          red_r <= red8(red_r, red_x[PROD_W-1:PROD_W-BYTE_W], m_eff);
          red_x <= red_x << BYTE_W;
          red_cnt <= red_cnt - 2'd1;
          if (red_cnt == 2'd1) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          unique case (op)
            OP_PH: begin
              ph <= red_r;
              if (plen >= LEN_W'(1)) begin
                op <= OP_LP;
                state <= ST_LOAD;
              end else begin
                plen <= plen + LEN_W'(1);
                state <= ST_IDLE;
              end
            end
            OP_LP: begin
              lp <= red_r;
              plen <= plen + LEN_W'(1);
              state <= ST_IDLE;
            end
            OP_LM: begin
              lm <= red_r;
              op <= OP_PM;
              state <= ST_LOAD;
            end
            OP_PM: begin
              pm <= red_r;
              op <= OP_DA;
              state <= ST_LOAD;
            end
            OP_DA: begin
              term <= red_r;
              op <= OP_HA;
              state <= ST_LOAD;
            end
            OP_HA: begin
              term <= sub_v;
              op <= OP_NA;
              state <= ST_LOAD;
            end
            OP_NA: begin
              ha <= red_r;
              op <= OP_DB;
              state <= ST_LOAD;
            end
            OP_DB: begin
              term <= red_r;
              op <= OP_HB;
              state <= ST_LOAD;
            end
            OP_HB: begin
              term <= sub_v;
              op <= OP_NB;
              state <= ST_LOAD;
            end
            OP_NB: begin
              hb <= red_r;
              seen <= seen_next;
              wpos <= (wpos_inc >= plen) ? '0 : ADDR_W'(wpos_inc);
              hit <= hit_next;
              count <= count_next;
              state <= ST_DONE;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_match <= hit;
            out_total <= total_of(count);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_wpos_in_window: assert property (@(posedge clk) disable iff (rst)
    plen != '0 |-> LEN_W'(wpos) < plen)
    else $error("window write position beyond pattern length");

  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen <= plen)
    else $error("text byte count exceeds pattern length");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside completion");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(accept && req.func == dtrh_pkg::FUNC_PATTERN && req.first)
    |-> count >= $past(count))
    else $error("match count decreased without restart");

endmodule

### test/dual_text_rolling_hash_match_unit_tb.sv
// Self-checking testbench for the dual-text rolling hash match unit.
module dual_text_rolling_hash_match_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BEATS = 700;

  typedef struct {
    logic            func;
    logic            first;
    dtrh_pkg::byte_t byte_a;
    dtrh_pkg::byte_t byte_b;
  } beat_t;

  typedef struct {
    logic             window_match;
    dtrh_pkg::total_t match_total;
  } match_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  dtrh_req_if req_ch();
  dtrh_rsp_if rsp_ch();

  dual_text_rolling_hash_match_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  beat_t           beat_q[$];
  match_result_t   match_q[$];
  dtrh_pkg::byte_t cur_pattern[$];

  int beats_queued = 0;
  int beats_sent = 0;
  int beats_taken = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int rdy_mode = 0;
  int rdy_mode_left = 0;
  int idle_cycles = 0;
  beat_t drv_beat;

  dtrh_pkg::hash_t modulus_copy = dtrh_pkg::MODULUS_RESET;
  dtrh_pkg::hash_t pat_hash = '0;
  dtrh_pkg::hash_t lead_pow = 16'd1;
  int              pat_len = 0;
  dtrh_pkg::hash_t text_hash_a = '0;
  dtrh_pkg::hash_t text_hash_b = '0;
  dtrh_pkg::byte_t win_a[dtrh_pkg::MAX_PATTERN];
  dtrh_pkg::byte_t win_b[dtrh_pkg::MAX_PATTERN];
  int              bytes_seen = 0;
  int              wr_pos = 0;
  longint unsigned match_count = 0;

  always #1 clk = ~clk;

  function automatic dtrh_pkg::hash_t roll_hash(dtrh_pkg::hash_t h, dtrh_pkg::byte_t oldest,
                                                dtrh_pkg::byte_t incoming, bit full,
                                                longint unsigned m);
    longint unsigned v;
    longint unsigned drop;
    v = h % m;
    if (full) begin
      drop = (oldest * (lead_pow % m)) % m;
      v = (v + m - drop) % m;
    end
    v = (v * 256 + incoming) % m;
    return dtrh_pkg::hash_t'(v);
  endfunction

  task automatic model_beat(logic func, logic first, dtrh_pkg::byte_t a, dtrh_pkg::byte_t b);
    longint unsigned m;
    longint unsigned p;
    bit full;
    logic hit;
    int pos;
    m = (modulus_copy == 0) ? 1 : modulus_copy;
    if (func == dtrh_pkg::FUNC_PATTERN) begin
      if (first) begin
        pat_hash = '0;
        lead_pow = 16'd1;
        pat_len = 0;
        match_count = 0;
      end
      text_hash_a = '0;
      text_hash_b = '0;
      bytes_seen = 0;
      wr_pos = 0;
      if (pat_len < dtrh_pkg::MAX_PATTERN) begin
        pat_hash = dtrh_pkg::hash_t'(((pat_hash % m) * 256 + a) % m);
        if (pat_len >= 1) lead_pow = dtrh_pkg::hash_t'(((lead_pow % m) * 256) % m);
        pat_len++;
      end
    end else begin
      hit = 1'b0;
      if (pat_len != 0) begin
        full = (bytes_seen >= pat_len);
        pos = wr_pos;
        text_hash_a = roll_hash(text_hash_a, win_a[pos], a, full, m);
        text_hash_b = roll_hash(text_hash_b, win_b[pos], b, full, m);
        win_a[pos] = a;
        win_b[pos] = b;
        wr_pos = (pos + 1 >= pat_len) ? 0 : pos + 1;
        if (!full) bytes_seen++;
        if (bytes_seen >= pat_len) begin
          p = pat_hash % m;
          if (text_hash_a == p && text_hash_b == p) begin
            hit = 1'b1;
            if (match_count < ((64'd1 << dtrh_pkg::COUNT_WIDTH) - 1)) match_count++;
          end
        end
      end
      match_q.push_back('{hit,
                          dtrh_pkg::total_t'((match_count > 65535) ? 65535 : match_count)});
    end
  endtask

  task automatic check_result(logic window_match, dtrh_pkg::total_t match_total);
    match_result_t want;
    if (match_q.size() == 0) begin
      $error("unexpected result: window_match %0d match_total %0d", window_match, match_total);
      errors++;
    end else begin
      want = match_q.pop_front();
      if (window_match !== want.window_match) begin
        $error("window_match expected %0d actual %0d", want.window_match, window_match);
        errors++;
      end
      if (match_total !== want.match_total) begin
        $error("match_total expected %0d actual %0d", want.match_total, match_total);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) check_result(rsp_ch.window_match, rsp_ch.match_total);
      if (req_ch.valid && req_ch.ready) begin
        beats_taken++;
        model_beat(req_ch.func, req_ch.first, req_ch.byte_a, req_ch.byte_b);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && beats_taken != beats_sent)) begin
      if (gap_left > 0) begin
        req_ch.valid <= 1'b0;
        gap_left--;
      end else if (beat_q.size() > 0) begin
        drv_beat = beat_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.func <= drv_beat.func;
        req_ch.first <= drv_beat.first;
        req_ch.byte_a <= drv_beat.byte_a;
        req_ch.byte_b <= drv_beat.byte_b;
        beats_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, $urandom_range(0, 1) ? 4 : 45);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rdy_mode_left == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_mode_left = $urandom_range(16, 256);
    end else begin
      rdy_mode_left--;
    end
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      case (rdy_mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= $urandom_range(0, 1);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 60);
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic push_beat(logic func, logic first, dtrh_pkg::byte_t a, dtrh_pkg::byte_t b);
    if (func == dtrh_pkg::FUNC_PATTERN) begin
      if (first) cur_pattern.delete();
      cur_pattern.push_back(a);
    end
    beat_q.push_back('{func, first, a, b});
    beats_queued++;
  endtask

  task automatic add_pattern(int n, bit fresh);
    for (int i = 0; i < n; i++)
      push_beat(dtrh_pkg::FUNC_PATTERN, fresh && (i == 0), dtrh_pkg::byte_t'($urandom),
                dtrh_pkg::byte_t'($urandom));
  endtask

  task automatic add_text(int n);
    int eff;
    int i;
    int bad;
    dtrh_pkg::byte_t a;
    dtrh_pkg::byte_t b;
    eff = (cur_pattern.size() > dtrh_pkg::MAX_PATTERN) ? dtrh_pkg::MAX_PATTERN
                                                       : cur_pattern.size();
    i = 0;
    while (i < n) begin
      if (eff > 0 && eff <= n - i && $urandom_range(0, 2) == 0) begin
        bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff - 1) : -1;
        for (int k = 0; k < eff; k++) begin
          a = cur_pattern[k];
          b = (k == bad) ? dtrh_pkg::byte_t'(a ^ dtrh_pkg::byte_t'($urandom_range(1, 255))) : a;
          push_beat(dtrh_pkg::FUNC_TEXT, $urandom_range(0, 7) == 0, a, b);
        end
        i += eff;
      end else begin
        a = dtrh_pkg::byte_t'($urandom);
        b = $urandom_range(0, 1) ? a : dtrh_pkg::byte_t'($urandom);
        push_beat(dtrh_pkg::FUNC_TEXT, $urandom_range(0, 7) == 0, a, b);
        i++;
      end
    end
  endtask

  task automatic drain();
    while (!(beat_q.size() == 0 && beats_taken == beats_sent && match_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(int unsigned value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[15:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    modulus_copy = value[15:0];
  endtask

  task automatic random_modulus();
    case ($urandom_range(0, 11))
      0: write_modulus(0);
      1: write_modulus(1);
      2: write_modulus(2);
      3: write_modulus(3);
      4: write_modulus(7);
      5: write_modulus(101);
      6: write_modulus(256);
      7: write_modulus(257);
      8: write_modulus(65521);
      9: write_modulus(65535);
      default: write_modulus($urandom_range(2, 65535));
    endcase
  endtask

  task automatic random_phase();
    int r;
    int len;
    int eff;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      len = $urandom_range(0, 19);
      if (len < 16) len = $urandom_range(1, 8);
      else if (len < 19) len = $urandom_range(9, dtrh_pkg::MAX_PATTERN);
      else len = $urandom_range(dtrh_pkg::MAX_PATTERN + 1, dtrh_pkg::MAX_PATTERN + 4);
      add_pattern(len, 1'b1);
    end else if (r <= 7) begin
      add_pattern($urandom_range(1, 3), 1'b0);
    end
    eff = (cur_pattern.size() > dtrh_pkg::MAX_PATTERN) ? dtrh_pkg::MAX_PATTERN
                                                       : cur_pattern.size();
    if ($urandom_range(0, 9) == 0) add_text($urandom_range(0, eff - 1));
    else add_text(eff + $urandom_range(0, 16));
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = dtrh_pkg::FUNC_PATTERN;
    req_ch.first = 1'b0;
    req_ch.byte_a = '0;
    req_ch.byte_b = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < dtrh_pkg::MAX_PATTERN; i++) begin
      win_a[i] = '0;
      win_b[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b1, 8'hFF, 8'hFF);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b1, 8'hFF, 8'h00);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b0, 8'h00, 8'hFF);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'hFF, 8'hFF);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b0, 8'h80, 8'h55);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'hFF, 8'hFF);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h80, 8'h80);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b1, 8'hFF, 8'hFF);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h80, 8'h80);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'hFF, 8'hFF);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h80, 8'h81);
    write_modulus(0);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b1, 8'h42, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h13, 8'hEC);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'hFF);
    write_modulus(65535);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b1, 8'h00, 8'hFF);
    push_beat(dtrh_pkg::FUNC_PATTERN, 1'b0, 8'hFF, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h00, 8'h00);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'hFF, 8'hFF);
    write_modulus(2);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h01, 8'h03);
    push_beat(dtrh_pkg::FUNC_TEXT, 1'b0, 8'h7F, 8'hFE);

    while (beats_queued < RANDOM_BEATS + 25) begin
      if ($urandom_range(0, 2) == 0) random_modulus();
      random_phase();
    end

    drain();
    if (errors == 0 && match_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
